@@ rtl/lip_pkg.sv @@
// shared types and constants for the linear interpolation upsampler
package lip_pkg;

	// configuration register defaults
	localparam logic [15:0] SRC_RATE_RESET = 16'd8363;
	localparam logic [15:0] DST_RATE_RESET = 16'd44100;

	// outputs emitted per source interval at most
	localparam int unsigned MAX_PER_INTERVAL = 32;
	localparam int unsigned CNT_W = $clog2(MAX_PER_INTERVAL);

	// default depth of the job queue between front and back
	localparam int unsigned JOB_QUEUE_DEPTH = 4;

	// configuration register index
	localparam int unsigned CFG_INDEX_W = 1;
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SOURCE_RATE = 1'b0,
		REG_TARGET_RATE = 1'b1
	} cfg_reg_t;

	// effective rates, zero already mapped to one
	typedef struct packed {
		logic [15:0] src;
		logic [15:0] dst;
	} rates_t;

	// one accepted source sample, classified by the front
	typedef struct packed {
		logic [7:0] prev;
		logic [7:0] cur;
		logic       have_prev;
		logic       last;
	} job_t;

	// back end sequencer states
	typedef enum logic [3:0] {
		BK_IDLE,
		BK_START,
		BK_MUL,
		BK_DIV_GO,
		BK_DIV_WAIT,
		BK_EMIT,
		BK_SKIP,
		BK_INT_DONE,
		BK_FLUSH
	} back_state_t;

endpackage

@@ rtl/linear_interp_upsampler.sv @@
// a step with one output shows it when the step flushes; with more outputs each leaves when the
// next one is computed, the last when the step flushes
// each output passes product, divider setup, a 2-bit-per-cycle divide with its done strobe, and
// emit; outputs past 32 in an interval are dropped, and the final interval of a stream runs as
// one more interval of the step; the queue buffers 4
// reset: rates return to 8363 and 44100, stream state, phase and queue are cleared at once
module linear_interp_upsampler #(
	parameter int unsigned JobQueueDepth = lip_pkg::JOB_QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lip_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]                     cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] sample
	input  logic                            s_axis_tlast,  // is_last
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [15:0]                     m_axis_tdata,  // [15:0] out_sample
	output logic                            m_axis_tlast   // end_of_stream
);
	import lip_pkg::*;

	rates_t rates;
	job_t   push_job;
	job_t   pop_job;
	logic   push;
	logic   pop;
	logic   q_full;
	logic   q_empty;

	lip_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.push          (push),
		.push_job      (push_job),
		.rates         (rates)
	);

	lip_job_queue #(
		.Depth (JobQueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	lip_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rates         (rates),
		.job           (pop_job),
		.q_empty       (q_empty),
		.q_pop         (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ rtl/lip_front.sv @@
// front end: configuration registers, input transfers and job classification
module lip_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lip_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [15:0]                        cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // [7:0] sample
	input  logic                               s_axis_tlast,  // is_last
	input  logic                               q_full,
	output logic                               push,
	output lip_pkg::job_t                      push_job,
	output lip_pkg::rates_t                    rates
);
	import lip_pkg::*;

	logic [15:0] src_rate_q;
	logic [15:0] dst_rate_q;
	logic [7:0]  prev_q;
	logic        have_prev_q;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_rate_q <= SRC_RATE_RESET;
			dst_rate_q <= DST_RATE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SOURCE_RATE: src_rate_q <= cfg_data;
				REG_TARGET_RATE: dst_rate_q <= cfg_data;
			endcase
		end
	end

	// a zero rate behaves as one
	assign rates.src = (src_rate_q == 16'd0) ? 16'd1 : src_rate_q;
	assign rates.dst = (dst_rate_q == 16'd0) ? 16'd1 : dst_rate_q;

	// accept while the queue has room
	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	assign push_job.prev      = prev_q;
	assign push_job.cur       = s_axis_tdata;
	assign push_job.have_prev = have_prev_q;
	assign push_job.last      = s_axis_tlast;

	// stream state: previous sample, cleared at the end of a stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= 8'd0;
			have_prev_q <= 1'b0;
		end else if (push) begin
			if (s_axis_tlast) begin
				prev_q      <= 8'd0;
				have_prev_q <= 1'b0;
			end else begin
				prev_q      <= s_axis_tdata;
				have_prev_q <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/lip_job_queue.sv @@
// short job queue between front and back
module lip_job_queue #(
	parameter int unsigned Depth = lip_pkg::JOB_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lip_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output lip_pkg::job_t pop_job,
	output logic          empty
);
	import lip_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	job_t            mem [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign pop_job = mem[rd_ptr_q];

	// storage write
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if ((push && !full) && !(pop && !empty)) begin
				count_q <= count_q + 1'b1;
			end else if (!(push && !full) && (pop && !empty)) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/lip_div.sv @@
// iterative unsigned divider, two quotient bits per cycle
module lip_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] divisor,
	input  logic [23:0] dividend,
	output logic        done,
	output logic [15:0] quotient
);
	localparam int unsigned QW    = 16;
	localparam int unsigned Steps = 2;
	localparam int unsigned Cyc   = QW / Steps;
	localparam int unsigned CycW  = $clog2(Cyc);

	logic            busy_q;
	logic            done_q;
	logic [CycW-1:0] cyc_q;
	logic [15:0]     rem_q;
	logic [15:0]     dvd_q;
	logic [15:0]     rem_nx;
	logic [15:0]     dvd_nx;
	logic [16:0]     trial;

	assign done     = done_q;
	assign quotient = dvd_q;

	// restoring steps; the quotient shifts into the dividend register
	always_comb begin
		rem_nx = rem_q;
		dvd_nx = dvd_q;
		trial  = '0;
		for (int i = 0; i < Steps; i++) begin
			trial  = {rem_nx, dvd_nx[QW-1]};
			dvd_nx = {dvd_nx[QW-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_nx    = 16'(trial - {1'b0, divisor});
				dvd_nx[0] = 1'b1;
			end else begin
				rem_nx = trial[15:0];
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cyc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cyc_q  <= '0;
			end else if (busy_q) begin
				cyc_q <= cyc_q + 1'b1;
				if (cyc_q == CycW'(Cyc - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and dividend/quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[23:8];
			dvd_q <= {dividend[7:0], 8'h00};
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= dvd_nx;
		end
	end

endmodule

@@ rtl/lip_back.sv @@
// back end: interval sequencer, interpolation arithmetic and output register
module lip_back (
	input  logic            clk,
	input  logic            arst_n,
	input  lip_pkg::rates_t rates,
	input  lip_pkg::job_t   job,
	input  logic            q_empty,
	output logic            q_pop,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [15:0]     m_axis_tdata,  // [15:0] out_sample
	output logic            m_axis_tlast   // end_of_stream
);
	import lip_pkg::*;

	back_state_t        st_q;
	back_state_t        st_d;
	logic [7:0]         s0_q;
	logic [7:0]         s1_q;
	logic               last_q;
	logic               pend_b_q;
	logic [15:0]        phase_q;
	logic [16:0]        pos_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [24:0] prod_a_s1;
	logic signed [24:0] prod_b_s1;
	logic               neg_q;
	logic               hold_valid_q;
	logic [15:0]        hold_data_q;
	logic               out_valid_q;
	logic [15:0]        out_data_q;
	logic               out_last_q;

	logic               out_free;
	logic               div_start;
	logic               div_done;
	logic [15:0]        div_q;
	logic               emit_go;
	logic               flush_go;
	logic               out_load;
	logic               out_load_last;
	logic [16:0]        newpos;
	logic               crossed;
	logic               phase_over;
	logic [15:0]        span;
	logic signed [24:0] sum;
	logic [23:0]        sum_abs;
	logic [15:0]        value;

	// position arithmetic
	assign newpos     = pos_q + {1'b0, rates.src};
	assign crossed    = newpos >= {1'b0, rates.dst};
	assign phase_over = phase_q >= rates.dst;
	assign span       = rates.dst - pos_q[15:0];

	// numerator magnitude and sign, result with sign restored
	assign sum     = prod_a_s1 + prod_b_s1;
	assign sum_abs = sum[24] ? 24'(-sum) : sum[23:0];
	assign value   = neg_q ? (~div_q + 16'd1) : div_q;

	lip_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (rates.dst),
		.dividend (sum_abs),
		.done     (div_done),
		.quotient (div_q)
	);

	// handshake strobes
	always_comb begin
		out_free      = !out_valid_q || m_axis_tready;
		q_pop         = (st_q == BK_IDLE) && !q_empty;
		div_start     = (st_q == BK_DIV_GO);
		emit_go       = (st_q == BK_EMIT) && (!hold_valid_q || out_free);
		flush_go      = (st_q == BK_FLUSH) && (!hold_valid_q || out_free);
		out_load      = (emit_go || flush_go) && hold_valid_q;
		out_load_last = flush_go && last_q;
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: begin
				if (!q_empty && (job.have_prev || job.last)) begin
					st_d = BK_START;
				end
			end
			BK_START: begin
				st_d = phase_over ? BK_INT_DONE : BK_MUL;
			end
			BK_MUL:      st_d = BK_DIV_GO;
			BK_DIV_GO:   st_d = BK_DIV_WAIT;
			BK_DIV_WAIT: begin
				if (div_done) begin
					st_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (emit_go) begin
					priority if (crossed) begin
						st_d = BK_INT_DONE;
					end else if (cnt_q == CNT_W'(MAX_PER_INTERVAL - 1)) begin
						st_d = BK_SKIP;
					end else begin
						st_d = BK_MUL;
					end
				end
			end
			BK_SKIP: begin
				if (crossed) begin
					st_d = BK_INT_DONE;
				end
			end
			BK_INT_DONE: begin
				st_d = pend_b_q ? BK_START : BK_FLUSH;
			end
			BK_FLUSH: begin
				if (flush_go) begin
					st_d = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= BK_IDLE;
			last_q       <= 1'b0;
			pend_b_q     <= 1'b0;
			phase_q      <= 16'd0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			st_q <= st_d;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (emit_go) begin
				hold_valid_q <= 1'b1;
			end else if (flush_go) begin
				hold_valid_q <= 1'b0;
			end

			unique case (st_q)
				BK_IDLE: begin
					if (q_pop) begin
						last_q   <= job.last;
						pend_b_q <= job.have_prev && job.last;
						if (!job.have_prev) begin
							phase_q <= 16'd0;
						end
					end
				end
				BK_START: begin
					if (phase_over) begin
						phase_q <= phase_q - rates.dst;
					end
				end
				BK_EMIT: begin
					if (emit_go && crossed) begin
						phase_q <= 16'(newpos - {1'b0, rates.dst});
					end
				end
				BK_SKIP: begin
					if (crossed) begin
						phase_q <= 16'(newpos - {1'b0, rates.dst});
					end
				end
				BK_INT_DONE: pend_b_q <= 1'b0;
				BK_FLUSH: begin
					if (flush_go && last_q) begin
						phase_q <= 16'd0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			BK_IDLE: begin
				if (q_pop) begin
					s0_q <= job.have_prev ? job.prev : job.cur;
					s1_q <= job.cur;
				end
			end
			BK_START: begin
				pos_q <= {1'b0, phase_q};
				cnt_q <= '0;
			end
			// s0*(T-pos) + s1*pos, registered per product
			BK_MUL: begin
				prod_a_s1 <= 25'($signed(s0_q) * $signed({1'b0, span}));
				prod_b_s1 <= 25'($signed(s1_q) * $signed({1'b0, pos_q[15:0]}));
			end
			BK_DIV_GO: neg_q <= sum[24];
			BK_EMIT: begin
				if (emit_go) begin
					hold_data_q <= value;
					pos_q       <= newpos;
					cnt_q       <= cnt_q + 1'b1;
				end
			end
			BK_SKIP:     pos_q <= newpos;
			BK_INT_DONE: s0_q  <= s1_q;
			default: ;
		endcase

		// output register
		if (out_load) begin
			out_data_q <= hold_data_q;
			out_last_q <= out_load_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

@@ bench/tb_linear_interp_upsampler.sv @@
// self-checking testbench for the linear interpolation upsampler
module tb_linear_interp_upsampler;
	timeunit 1ns;
	timeprecision 1ps;

	import lip_pkg::*;

	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 6;
	localparam int SETTLE_CYCLES = 400;
	localparam int SINK_HOLD_CYCLES = 300;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 15;
	localparam int REPORT_LIMIT = 10;
	localparam int RUN_LIMIT_NS = 1_000_000_000;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// one expected output transfer
	typedef struct packed {
		logic [15:0] value;
		logic        eos;
	} interp_out_t;

	// tracks stream state and interpolates expected outputs
	class interp_scoreboard;
		logic [15:0]        src_rate;
		logic [15:0]        dst_rate;
		logic signed [7:0]  prev_sample;
		bit                 have_prev;
		logic [15:0]        phase;
		interp_out_t        pending[$];
		int                 mismatches;
		int                 outputs_seen;
		int                 eos_seen;
		int                 samples_seen;
		int                 streams_seen;

		function new();
			src_rate = SRC_RATE_RESET;
			dst_rate = DST_RATE_RESET;
			prev_sample = '0;
			have_prev = 1'b0;
			phase = '0;
			mismatches = 0;
			outputs_seen = 0;
			eos_seen = 0;
			samples_seen = 0;
			streams_seen = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [15:0] val);
			if (idx == REG_SOURCE_RATE) begin
				src_rate = val;
			end else begin
				dst_rate = val;
			end
		endfunction

		// outputs between two source samples, capped per interval, phase advanced in full
		function int run_span(longint s0, longint s1);
			longint sr, tr, p, n, m, j, pos, num;
			interp_out_t item;
			sr = (src_rate == 16'd0) ? 64'd1 : longint'(src_rate);
			tr = (dst_rate == 16'd0) ? 64'd1 : longint'(dst_rate);
			p = longint'(phase);
			if (p >= tr) begin
				phase = 16'(p - tr);
				return 0;
			end
			n = (tr - p + sr - 1) / sr;
			m = (n > MAX_PER_INTERVAL) ? longint'(MAX_PER_INTERVAL) : n;
			for (j = 0; j < m; j++) begin
				pos = p + j * sr;
				num = 256 * (s0 * tr + (s1 - s0) * pos);
				item.value = 16'(num / tr);
				item.eos = 1'b0;
				pending.insert(pending.size(), item);
			end
			phase = 16'(p + n * sr - tr);
			return int'(m);
		endfunction

		function void note_sample(logic signed [7:0] smp, bit last);
			int produced;
			produced = 0;
			samples_seen++;
			if (have_prev) begin
				produced = run_span(prev_sample, smp);
			end else begin
				phase = '0;
			end
			prev_sample = smp;
			have_prev = 1'b1;
			// final interval holds the last sample flat, end flag on the last output of the step
			if (last) begin
				produced += run_span(smp, smp);
				if (produced > 0) begin
					pending[pending.size() - 1].eos = 1'b1;
				end
				prev_sample = '0;
				have_prev = 1'b0;
				phase = '0;
				streams_seen++;
			end
		endfunction

		function void check_result(logic [15:0] value, logic eos);
			interp_out_t want;
			outputs_seen++;
			if (eos) begin
				eos_seen++;
			end
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: unexpected output %0d eos %0b, nothing pending",
						$time, $signed(value), eos);
				end
				return;
			end
			want = pending.pop_front();
			if (want.value !== value || want.eos !== eos) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: output mismatch, expected %0d eos %0b, got %0d eos %0b",
						$time, $signed(want.value), want.eos, $signed(value), eos);
				end
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [15:0]            cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata;
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [15:0]            m_axis_tdata;
	logic                   m_axis_tlast;

	interp_scoreboard sb;
	int  src_idle_pct;
	int  sink_stall_pct;
	bit  hold_pending;
	int  rate_settings;

	linear_interp_upsampler u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("timeout with %0d outputs still pending", sb.pending.size());
		$display("FAILED: results differ");
		$finish;
	end

	// receiver ready, with random stalls and one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				m_axis_tready <= 1'b0;
				for (int c = 1; c < SINK_HOLD_CYCLES; c++) @(negedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// check every output transfer
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata, m_axis_tlast);
		end
	end

	function automatic void set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
			IDLE_SENDER: begin
				src_idle_pct = 58;
				sink_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				src_idle_pct = 0;
				sink_stall_pct = 58;
			end
			default: begin
				src_idle_pct = 7;
				sink_stall_pct = 7;
			end
		endcase
	endfunction

	// one register write; caller drops cfg_valid after the last one
	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic set_rates(logic [15:0] src, logic [15:0] dst);
		write_reg(REG_SOURCE_RATE, src);
		write_reg(REG_TARGET_RATE, dst);
		cfg_valid <= 1'b0;
		rate_settings++;
	endtask

	// one sample transfer, optional idle cycles ahead of it
	task automatic send_sample(logic [7:0] smp, bit last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_sample(smp, last);
		@(negedge clk);
	endtask

	task automatic send_seq(logic [7:0] seq[$]);
		foreach (seq[i]) begin
			send_sample(seq[i], i == seq.size() - 1);
		end
	endtask

	// sample values biased toward the signed extremes, zero and all ones
	function automatic logic [7:0] pick_sample();
		case ($urandom_range(7))
			0: return 8'h80;
			1: return 8'h7F;
			2: return 8'h00;
			3: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic pick_rates(output logic [15:0] src, output logic [15:0] dst);
		int kind, s, d;
		kind = $urandom_range(99);
		if (kind < 60) begin
			// moderate upsampling
			s = $urandom_range(1, 65535);
			d = s + $urandom_range(0, 7 * s);
			if (d > 65535) begin
				d = 65535;
			end
		end else if (kind < 85) begin
			// downsampling
			s = $urandom_range(1, 65535);
			d = $urandom_range(1, s);
		end else begin
			// steep ratios, often past the per-interval cap
			s = $urandom_range(1, 400);
			d = $urandom_range(s, 65535);
		end
		src = 16'(s);
		dst = 16'(d);
	endtask

	// wait for all expected outputs, then let zero-output work finish
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// main sequence
	initial begin
		logic [7:0] seq[$];
		logic [15:0] src, dst;
		int sent, len;
		sb = new();
		hold_pending = 1'b0;
		rate_settings = 1;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SOURCE_RATE;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		set_idling(IDLE_NONE);
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset rates: single-sample streams and full-swing streams
		seq = '{8'h7F};
		send_seq(seq);
		seq = '{8'h80};
		send_seq(seq);
		seq = '{8'h80, 8'h7F, 8'h80, 8'h7F, 8'h00, 8'hFF};
		send_seq(seq);
		seq = '{8'h00, 8'h55, 8'hAA};
		send_seq(seq);
		settle();

		// ratio of exactly the cap
		set_rates(16'd1, 16'd32);
		seq = '{8'h7F, 8'h80, 8'h05};
		send_seq(seq);
		settle();

		// ratio far above the cap, outputs dropped
		set_rates(16'd1, 16'd65535);
		seq = '{8'h80, 8'h7F};
		send_seq(seq);
		seq = '{8'h64};
		send_seq(seq);
		settle();

		// extreme downsampling, final step of the first stream emits nothing
		set_rates(16'd65535, 16'd1);
		seq = '{8'h11, 8'h80, 8'h7F, 8'hFF, 8'h22};
		send_seq(seq);
		seq = '{8'h80};
		send_seq(seq);
		settle();

		// zero registers act as one
		set_rates(16'd0, 16'd0);
		seq = '{8'h7F, 8'h80, 8'h01};
		send_seq(seq);
		settle();

		// mild downsampling
		set_rates(16'd3, 16'd2);
		seq = '{8'h80, 8'h7F, 8'h80, 8'h7F};
		send_seq(seq);
		settle();

		// random streams under random rates and idling
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			pick_rates(src, dst);
			set_rates(src, dst);
			set_idling(idle_mode_t'(ph % 4));
			if (ph == 4) begin
				// long receiver hold-off while samples keep coming
				hold_pending = 1'b1;
			end
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 10);
				for (int i = 0; i < len; i++) begin
					send_sample(pick_sample(), i == len - 1);
				end
				sent += len;
			end
			settle();
		end

		$display("covered %0d samples in %0d streams under %0d rate settings",
			sb.samples_seen, sb.streams_seen, rate_settings);
		$display("checked %0d output transfers, %0d of them ending a stream",
			sb.outputs_seen, sb.eos_seen);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
